### rtl/core/forward_obstacle_range_monitor_top_assert.svh
// Assertion macros for the forward obstacle range monitor.
// Included by the RTL file that checks its own control logic.
`ifndef FORWARD_OBSTACLE_RANGE_MONITOR_TOP_ASSERT_SVH
`define FORWARD_OBSTACLE_RANGE_MONITOR_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define FORM_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define FORM_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define FORM_ASSERT_IMP(label, clk, rst_n, ante, cons, msg)
`define FORM_ASSERT_NXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

### rtl/core/form_pkg.sv
// Shared types and constants of the forward obstacle range monitor.
// No dependencies.
`default_nettype none
package form_pkg;
    localparam int unsigned MaxWindowDef = 16;
    localparam int unsigned RangeBits = 23;
    localparam logic [22:0] DistMax = 23'h7FFFFF;
    localparam logic [16:0] SinA = 17'd51472;
    localparam logic [16:0] SinB = 17'd21024;
    localparam logic [16:0] SinC = 17'd2320;

    typedef enum logic [2:0] {
        CFG_WINDOW  = 3'd0,
        CFG_CLOSE   = 3'd1,
        CFG_TOO     = 3'd2,
        CFG_TOL     = 3'd3,
        CFG_BEAM    = 3'd4
    } t_cfg_idx;

    typedef enum logic [1:0] {
        ALERT_NONE  = 2'd0,
        ALERT_CLEAR = 2'd1,
        ALERT_NEAR  = 2'd2,
        ALERT_TOO   = 2'd3
    } t_alert;

    typedef enum logic [3:0] {
        ST_IDLE, ST_WIN, ST_DIV, ST_SIN0, ST_SIN1, ST_SIN2, ST_SIN3, ST_PROJ,
        ST_EDGE, ST_DONE, ST_OUT
    } t_state;
endpackage
`default_nettype wire

### rtl/core/forward_obstacle_range_monitor_top.sv
// Forward obstacle range monitor: sequencer, window store, shared multiplier.
// Depends on form_pkg, form_div, form_mul and the assertion macro header.
//
// Channel     Dir  Beat contents
// s_axis      in   tuser: func; tdata: depth, altitude, pitch, range, range_valid
// m_axis      out  distance_mm, distance_valid, alert
// cfg         in   register index, write data
//
// A usable range item passes the window update, the bit-serial divider and the
// multiplier steps of the lower and the upper beam edge.
// Synchronous active-low reset; the average window needs no clearing pass.
// Input is held off while a result waits on m_axis.
`default_nettype none
`include "forward_obstacle_range_monitor_top_assert.svh"
module forward_obstacle_range_monitor_top #(
    parameter int unsigned MAX_WINDOW = form_pkg::MaxWindowDef
) (
    input  wire          i_clk,
    input  wire          i_rst_n,
    input  wire          s_axis_tvalid,
    output logic         s_axis_tready,
    // func
    input  wire          s_axis_tuser,
    // depth_mm[24], altitude_mm[24], pitch_angle[16], range_mm, range_valid
    input  wire  [((64 + form_pkg::RangeBits + 1 + 7) / 8) * 8 - 1:0] s_axis_tdata,
    output logic         m_axis_tvalid,
    input  wire          m_axis_tready,
    // distance_mm[23], distance_valid, alert[2]
    output logic [31:0]  m_axis_tdata,
    input  wire          i_cfg_valid,
    output logic         o_cfg_ready,
    input  wire  [2:0]   i_cfg_index,
    input  wire  [22:0]  i_cfg_data
);
    import form_pkg::*;
    localparam int unsigned SumBits = RangeBits + $clog2(MAX_WINDOW + 1);
    localparam int unsigned WinBits = $clog2(MAX_WINDOW + 1);
    localparam int unsigned SlotBits = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int unsigned RangeLsb = 64;

    logic [4:0]  r_win_cfg;
    logic [22:0] r_close, r_too, r_tol;
    logic [14:0] r_beam;
    logic        r_active, r_last_valid;
    logic signed [23:0] r_depth, r_alt;
    logic [15:0] r_pitch;
    logic [RangeBits-1:0] r_window [MAX_WINDOW];
    logic [SumBits-1:0] r_sum;
    logic [WinBits-1:0] r_count;
    logic [SlotBits-1:0] r_slot;
    logic [22:0] r_last_dist;
    logic [RangeBits-1:0] r_range, r_old;
    logic [SumBits-1:0] r_avg;
    t_state r_state, n_state;
    logic [31:0] r_out;
    logic r_out_valid;
    logic r_edge;
    logic [14:0] r_z;
    logic [16:0] r_tmp;
    logic r_neg;
    logic signed [25:0] r_lower;
    logic r_hit;
    logic [WinBits-1:0] w_win;
    logic [SlotBits-1:0] w_slot;
    logic w_full;
    logic [SumBits-1:0] w_sum_nxt;
    logic [WinBits-1:0] w_cnt_nxt;
    logic w_div_start;
    logic w_div_busy;
    logic [SumBits-1:0] w_quot;
    logic [23:0] w_ma;
    logic [16:0] w_mb;
    logic [40:0] w_mp;
    logic [15:0] w_ang;
    logic [14:0] w_z;
    logic signed [25:0] w_proj;
    logic [RangeBits-1:0] w_in_range;
    logic w_in_func, w_in_rv;
    logic w_acc;
    t_alert w_alert;

    assign w_in_func  = s_axis_tuser;
    assign w_in_range = s_axis_tdata[RangeLsb +: RangeBits];
    assign w_in_rv    = s_axis_tdata[RangeLsb + RangeBits];
    assign s_axis_tready = (r_state == ST_IDLE) && !r_out_valid;
    assign w_acc = s_axis_tvalid && s_axis_tready;
    assign o_cfg_ready = (r_state == ST_IDLE);

    always_comb begin
        if (r_win_cfg == 5'd0) begin
            w_win = WinBits'(1);
        end else if (32'(r_win_cfg) > MAX_WINDOW) begin
            w_win = WinBits'(MAX_WINDOW);
        end else begin
            w_win = WinBits'(r_win_cfg);
        end
        w_slot = (32'(r_slot) >= 32'(w_win)) ? '0 : r_slot;
        w_full = (r_count >= w_win);
        w_sum_nxt = (w_full ? r_sum - SumBits'(r_old) : r_sum) + SumBits'(r_range);
        w_cnt_nxt = w_full ? r_count : r_count + 1'b1;
    end

    form_div #(.NUM_BITS(SumBits), .DEN_BITS(WinBits)) u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(w_div_start),
        .i_num(w_sum_nxt), .i_den(w_cnt_nxt), .o_busy(w_div_busy), .o_quot(w_quot)
    );

    assign w_ang = r_edge ? (r_pitch + 16'(r_beam[14:1])) : (r_pitch - 16'(r_beam[14:1]));
    assign w_z = w_ang[14] ? (15'd16384 - 15'(w_ang[13:0])) : 15'(w_ang[13:0]);

    always_comb begin
        unique case (r_state)
            ST_SIN0: begin w_ma = 24'(w_z); w_mb = 17'(w_z); end
            ST_SIN1: begin w_ma = 24'(w_mp[40:14]); w_mb = SinC; end
            ST_SIN2: begin w_ma = 24'(r_tmp); w_mb = SinB - 17'(w_mp[40:14]); end
            ST_SIN3: begin w_ma = 24'(r_z); w_mb = SinA - 17'(w_mp[40:14]); end
            ST_PROJ: begin w_ma = 24'(r_avg); w_mb = 17'(w_mp[40:14]); end
            default: begin w_ma = '0; w_mb = '0; end
        endcase
    end

    form_mul u_mul (.i_clk(i_clk), .i_a(w_ma), .i_b(w_mb), .o_p(w_mp));

    assign w_proj = r_neg ? -26'(w_mp[38:15]) : 26'(w_mp[38:15]);

    always_comb begin
        if (r_avg < SumBits'(r_too)) begin
            w_alert = ALERT_TOO;
        end else if (r_avg < SumBits'(r_close)) begin
            w_alert = ALERT_NEAR;
        end else begin
            w_alert = ALERT_CLEAR;
        end
    end

    always_comb begin
        n_state = r_state;
        w_div_start = 1'b0;
        unique case (r_state)
            ST_IDLE: if (w_acc && w_in_func && r_active && w_in_rv && r_depth > 0
                         && w_in_range > RangeBits'(100)) begin
                n_state = ST_WIN;
            end
            ST_WIN:  begin n_state = ST_DIV; w_div_start = 1'b1; end
            ST_DIV:  if (!w_div_busy) n_state = ST_SIN0;
            ST_SIN0: n_state = ST_SIN1;
            ST_SIN1: n_state = ST_SIN2;
            ST_SIN2: n_state = ST_SIN3;
            ST_SIN3: n_state = ST_PROJ;
            ST_PROJ: n_state = ST_EDGE;
            ST_EDGE: n_state = r_edge ? ST_DONE : ST_SIN0;
            ST_DONE: n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_old <= r_window[w_slot];
        end
        if (r_state == ST_WIN) begin
            r_window[w_slot] <= r_range;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_win_cfg <= 5'd5;
            r_close <= 23'd10000;
            r_too <= 23'd5000;
            r_tol <= 23'd500;
            r_beam <= 15'd1820;
            r_active <= 1'b0;
            r_depth <= '0;
            r_alt <= -24'sd1;
            r_pitch <= '0;
            r_sum <= '0;
            r_count <= '0;
            r_slot <= '0;
            r_last_dist <= DistMax;
            r_last_valid <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (m_axis_tvalid && m_axis_tready) r_out_valid <= 1'b0;
            if (i_cfg_valid && o_cfg_ready) begin
                unique case (i_cfg_index)
                    CFG_WINDOW: begin
                        r_win_cfg <= i_cfg_data[4:0];
                        r_sum <= '0; r_count <= '0; r_slot <= '0;
                    end
                    CFG_CLOSE: r_close <= i_cfg_data;
                    CFG_TOO:   r_too <= i_cfg_data;
                    CFG_TOL:   r_tol <= i_cfg_data;
                    CFG_BEAM:  r_beam <= i_cfg_data[14:0];
                    default: ;
                endcase
            end
            if (w_acc) begin
                r_range <= w_in_range;
                if (!w_in_func) begin
                    r_depth <= s_axis_tdata[23:0];
                    r_alt <= s_axis_tdata[47:24];
                    r_pitch <= s_axis_tdata[63:48];
                    r_active <= 1'b1;
                end else if (r_active && n_state == ST_IDLE) begin
                    r_out <= {6'd0, ALERT_NONE, r_last_valid, r_last_dist};
                    r_out_valid <= 1'b1;
                end
            end
            if (r_state == ST_WIN) begin
                r_sum <= w_sum_nxt;
                r_count <= w_cnt_nxt;
                r_slot <= (32'(w_slot) + 1 >= 32'(w_win)) ? '0 : w_slot + 1'b1;
            end
            if (r_state == ST_DONE) begin
                r_last_dist <= r_avg[22:0];
                r_last_valid <= !r_hit;
                r_out <= {6'd0, r_hit ? ALERT_NONE : w_alert, !r_hit, r_avg[22:0]};
                r_out_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            ST_DIV: begin
                r_avg <= w_quot;
                r_edge <= 1'b0;
                r_hit <= 1'b0;
            end
            ST_SIN0: begin
                r_z <= w_z;
                r_neg <= w_ang[15];
            end
            ST_SIN1: r_tmp <= 17'(w_mp[40:14]);
            ST_EDGE: begin
                if (!r_edge) begin
                    r_lower <= w_proj;
                end else begin
                    if (!r_alt[23] && (26'(r_alt) + r_lower) < $signed(26'(r_tol)))
                        r_hit <= 1'b1;
                    if ((26'(r_depth) - w_proj) < $signed(26'(r_tol))) r_hit <= 1'b1;
                end
                r_edge <= !r_edge;
            end
            default: ;
        endcase
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata = r_out;

    `FORM_ASSERT_IMP(a_no_cfg_busy, i_clk, i_rst_n, r_state != ST_IDLE, !o_cfg_ready, "cfg ready while busy")
    `FORM_ASSERT_NXT(a_done_out, i_clk, i_rst_n, r_state == ST_DONE, r_out_valid, "no result after done")
    `FORM_ASSERT_IMP(a_count_cap, i_clk, i_rst_n, 1'b1, 32'(r_count) <= MAX_WINDOW, "count overflow")
endmodule
`default_nettype wire

### rtl/core/form_div.sv
// Restoring divider, one quotient bit per cycle.
// Depends on form_pkg.
`default_nettype none
module form_div #(
    parameter int unsigned NUM_BITS = 29,
    parameter int unsigned DEN_BITS = 7
) (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_start,
    input  wire  [NUM_BITS-1:0]   i_num,
    input  wire  [DEN_BITS-1:0]   i_den,
    output logic                  o_busy,
    output logic [NUM_BITS-1:0]   o_quot
);
    import form_pkg::*;
    localparam int unsigned CntBits = $clog2(NUM_BITS + 1);
    logic [NUM_BITS-1:0] r_quot, n_quot;
    logic [DEN_BITS:0]   r_rem, n_rem;
    logic [DEN_BITS-1:0] r_den;
    logic [CntBits-1:0]  r_cnt;
    logic [DEN_BITS:0]   w_shift;

    always_comb begin
        w_shift = {r_rem[DEN_BITS-1:0], r_quot[NUM_BITS-1]};
        n_quot  = {r_quot[NUM_BITS-2:0], 1'b0};
        n_rem   = w_shift;
        if (w_shift >= {1'b0, r_den}) begin
            n_rem     = w_shift - {1'b0, r_den};
            n_quot[0] = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_start) begin
            r_cnt <= CntBits'(NUM_BITS);
        end else if (r_cnt != '0) begin
            r_cnt <= r_cnt - 1'b1;
        end
        if (i_start) begin
            r_quot <= i_num;
            r_rem  <= '0;
            r_den  <= i_den;
        end else if (r_cnt != '0) begin
            r_quot <= n_quot;
            r_rem  <= n_rem;
        end
    end

    assign o_busy = (r_cnt != '0);
    assign o_quot = r_quot;
endmodule
`default_nettype wire

### rtl/core/form_mul.sv
// Shared registered multiplier, 24 x 17 bits unsigned.
// Depends on form_pkg.
`default_nettype none
module form_mul (
    input  wire         i_clk,
    input  wire  [23:0] i_a,
    input  wire  [16:0] i_b,
    output logic [40:0] o_p
);
    import form_pkg::*;
    always_ff @(posedge i_clk) begin
        o_p <= 41'(i_a) * 41'(i_b);
    end
endmodule
`default_nettype wire

### tb/tb_forward_obstacle_range_monitor_top.sv
// Self-checking testbench of forward_obstacle_range_monitor_top: random and directed
// vehicle-state and range beats, with a transaction-level predictor of the averaged distance and alert.
// Depends on form_pkg and the RTL of the monitor only.
module tb_forward_obstacle_range_monitor_top;
    import form_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned WDOG_LIMIT = 20000;
    localparam int unsigned SETTLE = 150;

    typedef struct {
        bit               func;
        logic signed [23:0] depth;
        logic signed [23:0] alt;
        logic signed [15:0] pitch;
        logic [22:0]      range;
        bit               rvalid;
    } t_beat;

    typedef struct {
        logic [22:0] distance;
        bit          dvalid;
        t_alert      alert;
    } t_range_report;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    wire         s_axis_tready;
    logic        s_axis_tuser = 1'b0;
    logic [87:0] s_axis_tdata = '0;
    wire         m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    wire  [31:0] m_axis_tdata;
    logic        i_cfg_valid = 1'b0;
    wire         o_cfg_ready;
    logic [2:0]  i_cfg_index = '0;
    logic [22:0] i_cfg_data = '0;

    forward_obstacle_range_monitor_top dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tuser(s_axis_tuser), .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // predictor state and register copies
    bit          mon_active;
    longint      nav_depth, nav_alt;
    logic [15:0] nav_pitch;
    longint      win_buf [16];
    longint      win_total;
    int          win_fill, win_slot;
    logic [22:0] held_dist;
    bit          held_valid;
    logic [4:0]  cfg_win;
    logic [22:0] cfg_close, cfg_too, cfg_tol;
    logic [14:0] cfg_beam;

    t_beat         pending_beats [$];
    t_range_report expected_reports [$];
    t_beat         tx_beat;
    int  tx_idle_pct, rx_idle_pct;
    bit  rx_hold;
    int  errors, beats_in, reports_seen, cfg_writes, quiet_cycles;
    int  alert_hits [4];
    int  invalid_hits;

    task automatic report_mismatch(string what, longint got, longint want);
        $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
        errors++;
    endtask

    function automatic longint beam_sine(logic [15:0] ang);
        longint z, z2, p, s;
        longint r;
        r = ang[13:0];
        z = ang[14] ? 16384 - r : r;
        z2 = (z * z) >>> 14;
        p = 21024 - ((z2 * 2320) >>> 14);
        p = 51472 - ((z2 * p) >>> 14);
        s = (z * p) >>> 14;
        return ang[15] ? -s : s;
    endfunction

    function automatic longint edge_offset(longint avg, longint sine);
        if (sine < 0) return -((avg * -sine) >>> 15);
        return (avg * sine) >>> 15;
    endfunction

    function automatic logic [87:0] pack_beat(t_beat b);
        logic [87:0] d;
        d = '0;
        d[23:0] = b.depth;
        d[47:24] = b.alt;
        d[63:48] = b.pitch;
        d[86:64] = b.range;
        d[87] = b.rvalid;
        return d;
    endfunction

    task automatic apply_register(t_cfg_idx idx, logic [22:0] val);
        case (idx)
            CFG_WINDOW: begin
                cfg_win = val[4:0];
                win_total = 0;
                win_fill = 0;
                win_slot = 0;
                foreach (win_buf[k]) win_buf[k] = 0;
            end
            CFG_CLOSE: cfg_close = val;
            CFG_TOO:   cfg_too = val;
            CFG_TOL:   cfg_tol = val;
            CFG_BEAM:  cfg_beam = val[14:0];
            default: ;
        endcase
    endtask

    task automatic predict_range_report(t_beat b);
        t_range_report rep;
        int win;
        longint avg, lower, upper, tol;
        logic [15:0] half;
        bit hit;
        if (!b.func) begin
            nav_depth = b.depth;
            nav_alt = b.alt;
            nav_pitch = b.pitch;
            mon_active = 1'b1;
            return;
        end
        if (!mon_active) return;
        if (!b.rvalid || nav_depth <= 0 || b.range <= 100) begin
            rep.distance = held_dist;
            rep.dvalid = held_valid;
            rep.alert = ALERT_NONE;
            expected_reports.push_back(rep);
            return;
        end
        win = (cfg_win == 0) ? 1 : (cfg_win > 16) ? 16 : cfg_win;
        if (win_slot >= win) win_slot = 0;
        if (win_fill >= win) win_total -= win_buf[win_slot];
        else win_fill++;
        win_buf[win_slot] = longint'(b.range);
        win_total += longint'(b.range);
        win_slot = (win_slot + 1 >= win) ? 0 : win_slot + 1;
        avg = win_total / win_fill;
        half = 16'(cfg_beam[14:1]);
        lower = edge_offset(avg, beam_sine(nav_pitch - half));
        upper = edge_offset(avg, beam_sine(nav_pitch + half));
        tol = longint'(cfg_tol);
        hit = (nav_alt >= 0 && nav_alt + lower < tol) || (nav_depth - upper < tol);
        if (hit) rep.alert = ALERT_NONE;
        else if (avg < longint'(cfg_too)) rep.alert = ALERT_TOO;
        else if (avg < longint'(cfg_close)) rep.alert = ALERT_NEAR;
        else rep.alert = ALERT_CLEAR;
        held_valid = !hit;
        held_dist = avg[22:0];
        rep.distance = held_dist;
        rep.dvalid = held_valid;
        expected_reports.push_back(rep);
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                predict_range_report(tx_beat);
                beats_in++;
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (pending_beats.size() > 0 && $urandom_range(99) >= tx_idle_pct) begin
                    tx_beat = pending_beats.pop_front();
                    s_axis_tuser <= tx_beat.func;
                    s_axis_tdata <= pack_beat(tx_beat);
                    s_axis_tvalid <= 1'b1;
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        t_range_report want;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                reports_seen++;
                if (expected_reports.size() == 0) begin
                    report_mismatch("unexpected beat, distance",
                                    longint'(m_axis_tdata[22:0]), -1);
                end else begin
                    want = expected_reports.pop_front();
                    alert_hits[want.alert]++;
                    if (!want.dvalid) invalid_hits++;
                    if (m_axis_tdata[22:0] !== want.distance)
                        report_mismatch("distance_mm", longint'(m_axis_tdata[22:0]),
                                        longint'(want.distance));
                    if (m_axis_tdata[23] !== want.dvalid)
                        report_mismatch("distance_valid", longint'(m_axis_tdata[23]),
                                        longint'(want.dvalid));
                    if (m_axis_tdata[25:24] !== want.alert)
                        report_mismatch("alert", longint'(m_axis_tdata[25:24]),
                                        longint'(want.alert));
                end
            end
            m_axis_tready <= !rx_hold && ($urandom_range(99) >= rx_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
                || (i_cfg_valid && o_cfg_ready) || !i_rst_n) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles + 1 >= WDOG_LIMIT) begin
            $display("watchdog expired with %0d results outstanding",
                     expected_reports.size());
            $display("RESULT: ERROR");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // long receiver hold-off while the sender keeps offering beats
    initial begin
        rx_hold = 1'b0;
        wait (beats_in > 40);
        @(posedge i_clk);
        rx_hold <= 1'b1;
        repeat (600) @(posedge i_clk);
        rx_hold <= 1'b0;
    end

    task automatic write_register(t_cfg_idx idx, logic [22:0] val);
        i_cfg_index <= idx;
        i_cfg_data <= val;
        i_cfg_valid <= 1'b1;
        do @(posedge i_clk); while (!o_cfg_ready);
        apply_register(idx, val);
        cfg_writes++;
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic drain();
        do @(posedge i_clk);
        while (pending_beats.size() > 0 || s_axis_tvalid || expected_reports.size() > 0);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic add_beat(bit func, longint depth, longint alt, longint pitch,
                            longint range, bit rvalid);
        t_beat b;
        b.func = func;
        b.depth = 24'(depth);
        b.alt = 24'(alt);
        b.pitch = 16'(pitch);
        b.range = 23'(range);
        b.rvalid = rvalid;
        pending_beats.push_back(b);
    endtask

    task automatic add_random_beats(int count);
        t_beat b;
        int sel;
        repeat (count) begin
            sel = $urandom_range(99);
            b.func = (sel >= 25);
            b.depth = ($urandom_range(9) == 0) ? 24'($urandom)
                    : 24'($urandom_range(200000, 1));
            b.alt = ($urandom_range(9) == 0) ? 24'($urandom)
                  : ($urandom_range(5) == 0) ? 24'h FFFFFF
                  : 24'($urandom_range(100000, 0));
            b.pitch = ($urandom_range(9) == 0) ? 16'($urandom)
                    : 16'($urandom_range(6000) - 3000);
            case ($urandom_range(9))
                0: b.range = 23'($urandom);
                1: b.range = 23'($urandom_range(110));
                2, 3: b.range = 23'($urandom_range(8000, 101));
                default: b.range = 23'($urandom_range(40000, 101));
            endcase
            b.rvalid = ($urandom_range(7) != 0);
            pending_beats.push_back(b);
        end
    endtask

    initial begin
        mon_active = 1'b0;
        nav_depth = 0;
        nav_alt = -1;
        nav_pitch = '0;
        held_dist = DistMax;
        held_valid = 1'b0;
        cfg_win = 5'd5;
        cfg_close = 23'd10000;
        cfg_too = 23'd5000;
        cfg_tol = 23'd500;
        cfg_beam = 15'd1820;
        win_total = 0;
        win_fill = 0;
        win_slot = 0;
        foreach (win_buf[k]) win_buf[k] = 0;
        tx_idle_pct = 12;
        rx_idle_pct = 53;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // inactive, then depth zero, then the dropout threshold and extremes
        add_beat(1, 0, 0, 0, 5000, 1);
        add_beat(0, 0, 20000, 0, 0, 0);
        add_beat(1, 0, 0, 0, 5000, 1);
        add_beat(0, 30000, 20000, 0, 0, 0);
        add_beat(1, 0, 0, 0, 100, 1);
        add_beat(1, 0, 0, 0, 101, 1);
        add_beat(1, 0, 0, 0, 8388607, 0);
        add_beat(1, 0, 0, 0, 8000, 1);
        add_beat(1, 0, 0, 0, 20000, 1);
        add_beat(1, 0, 0, 0, 8388607, 1);
        add_beat(0, 8388607, -8388608, -32768, 8388607, 1);
        add_beat(1, 0, 0, 0, 3000, 1);
        add_beat(0, -8388608, 8388607, 32767, 0, 0);
        add_beat(1, 0, 0, 0, 3000, 1);
        add_beat(0, 500, 100000, 16384, 0, 0);
        add_beat(1, 0, 0, 0, 20000, 1);
        add_beat(0, 200000, 300, -16384, 0, 0);
        add_beat(1, 0, 0, 0, 20000, 1);
        add_beat(0, 200000, -1, 0, 0, 0);
        add_beat(1, 0, 0, 0, 4000, 1);
        drain();

        write_register(CFG_WINDOW, 23'd0);
        write_register(CFG_CLOSE, 23'h7FFFFF);
        write_register(CFG_TOO, 23'd0);
        write_register(CFG_TOL, 23'd0);
        write_register(CFG_BEAM, 23'h7FFF);
        add_random_beats(150);
        drain();

        write_register(CFG_WINDOW, 23'd16);
        write_register(CFG_CLOSE, 23'd12000);
        write_register(CFG_TOO, 23'd6000);
        write_register(CFG_TOL, 23'h7FFFFF);
        write_register(CFG_BEAM, 23'd0);
        add_random_beats(60);
        drain();

        write_register(CFG_TOL, 23'd300);
        write_register(CFG_BEAM, 23'd2500);
        write_register(CFG_WINDOW, 23'd31);
        tx_idle_pct = 53;
        rx_idle_pct = 12;
        add_random_beats(300);
        drain();

        write_register(CFG_WINDOW, 23'd1);
        write_register(CFG_CLOSE, 23'd15000);
        write_register(CFG_TOO, 23'h7FFFFF);
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        add_random_beats(120);
        drain();

        write_register(CFG_WINDOW, 23'd7);
        write_register(CFG_TOO, 23'd4000);
        write_register(CFG_BEAM, 23'd1820);
        add_random_beats(250);
        drain();

        $display("%0d input beats, %0d results, %0d register writes", beats_in,
                 reports_seen, cfg_writes);
        $display("alerts none/clear/near/too: %0d/%0d/%0d/%0d, invalid distances: %0d",
                 alert_hits[0], alert_hits[1], alert_hits[2], alert_hits[3], invalid_hits);
        if (errors == 0 && expected_reports.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end
endmodule

### filelist.f
+incdir+rtl/core
rtl/core/form_pkg.sv
rtl/core/form_div.sv
rtl/core/form_mul.sv
rtl/core/forward_obstacle_range_monitor_top.sv
tb/tb_forward_obstacle_range_monitor_top.sv
